// File: design/lfpd_pkg.sv
// Shared types, constants and helpers for the line-follow PD steering block.
package lfpd_pkg;

  localparam int SENSOR_COUNT = 8;

  // Error is kept in units of 1/ERR_SCALE of a sensor pitch.
  localparam int ERR_SCALE = 840;
  localparam int LOST_ERR  = 4200;
  localparam int TURN_DIV  = ERR_SCALE * 256;

  localparam int ERR_W    = 14;
  localparam int DELTA_W  = 15;
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 12;
  localparam int DRIVE_W  = 13;
  localparam int SUM_W    = 14;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int RECIP_W  = 11;
  localparam int CNT_W    = 4;

  // Shared arithmetic unit widths.
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int ACC_W     = 40;
  localparam int QUO_W     = 12;

  // TURN_DIV is 105 << 11: shift off the power of two, then multiply by
  // ceil(2^26 / 105) and keep the bits above 2^26. Exact for magnitudes below 2^30.
  localparam int DIV_PRE   = 11;
  localparam int DIV_ODD   = TURN_DIV >> DIV_PRE;
  localparam int RCP_SHIFT = 26;
  localparam int MAG_W     = 30 - DIV_PRE;
  localparam int MUL_X_W   = MAG_W + 1;
  localparam int MUL_Y_W   = 21;
  localparam logic [MUL_Y_W-1:0] RCP_MUL = MUL_Y_W'((2 ** RCP_SHIFT + DIV_ODD - 1) / DIV_ODD);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY    = 3'd4;

  localparam logic [SPEED_W-1:0] CRUISE_RST      = 12'd300;
  localparam logic [SPEED_W-1:0] DRIVE_LIMIT_RST = 12'd1000;
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd7680;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd2560;

  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef enum logic [2:0] {
    ALU_NOP = 3'd0,
    ALU_MUL = 3'd1,
    ALU_MAC = 3'd2,
    ALU_ABS = 3'd3,
    ALU_RCP = 3'd4
  } alu_op_t;

  typedef struct packed {
    alu_op_t                     op;
    logic signed [DELTA_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
  } alu_ctl_t;

  // ERR_SCALE divided by the number of active sensors.
  function automatic logic [RECIP_W-1:0] scale_recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd1:    r = 11'd840;
      4'd2:    r = 11'd420;
      4'd3:    r = 11'd280;
      4'd4:    r = 11'd210;
      4'd5:    r = 11'd168;
      4'd6:    r = 11'd140;
      4'd7:    r = 11'd120;
      4'd8:    r = 11'd105;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/lfpd_err.sv
// Position error from one sensor sample: weighted centroid or lost-line fallback.
module lfpd_err #(
  parameter int SENSOR_COUNT = lfpd_pkg::SENSOR_COUNT
) (
  input  logic [SENSOR_COUNT-1:0] bits,
  input  logic                    polarity,
  input  lfpd_pkg::err_t          prev_error,
  output lfpd_pkg::err_t          err,
  output logic                    lost
);
  import lfpd_pkg::*;

  localparam int HALF   = SENSOR_COUNT / 2;
  localparam int WSUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT) + 1;
  localparam int CW     = $clog2(SENSOR_COUNT + 1);
  localparam int PROD_W = WSUM_W + RECIP_W + 1;

  logic [SENSOR_COUNT-1:0]    active;
  logic [CW-1:0]              count;
  logic signed [WSUM_W-1:0]   wsum;
  logic [RECIP_W-1:0]         recip;
  logic signed [PROD_W-1:0]   prod;

  assign active = polarity ? bits : ~bits;

  always_comb begin
    count = '0;
    wsum  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (active[i]) begin
        count = count + CW'(1);
        wsum  = wsum + ((i < HALF) ? WSUM_W'(i - HALF) : WSUM_W'(i - HALF + 1));
      end
    end
  end

  assign recip = scale_recip(CNT_W'(count));
  assign prod  = wsum * $signed({1'b0, recip});
  assign lost  = (count == '0);

  always_comb begin
    if (!lost) begin
      err = prod[ERR_W-1:0];
    end else if (prev_error > 0) begin
      err = ERR_W'(LOST_ERR);
    end else if (prev_error < 0) begin
      err = -ERR_W'(LOST_ERR);
    end else begin
      err = '0;
    end
  end

endmodule

// File: design/lfpd_alu.sv
// Shared arithmetic unit: multiply, multiply-accumulate, magnitude and reciprocal divide.
module lfpd_alu (
  input  logic                              clk,
  input  lfpd_pkg::alu_ctl_t                ctl,
  output logic [lfpd_pkg::QUO_W-1:0]        quo,
  output logic                              neg
);
  import lfpd_pkg::*;

  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           prod;
  logic signed [ACC_W-1:0]           mag;
  logic [MAG_W-1:0]                  mag_q;
  logic signed [MUL_X_W-1:0]         mul_x;
  logic signed [MUL_Y_W-1:0]         mul_y;
  logic signed [MUL_X_W+MUL_Y_W-1:0] full;

  // one multiplier: PD products, or the shifted magnitude times the reciprocal
  always_comb begin
    if (ctl.op == ALU_RCP) begin
      mul_x = $signed({1'b0, mag_q});
      mul_y = $signed(RCP_MUL);
    end else begin
      mul_x = MUL_X_W'(ctl.mul_a);
      mul_y = MUL_Y_W'(ctl.mul_b);
    end
  end

  assign full = mul_x * mul_y;
  assign prod = full[ACC_W-1:0];
  assign mag  = (acc < 0) ? -acc : acc;
  assign quo  = acc[RCP_SHIFT +: QUO_W];

  always_ff @(posedge clk) begin
    case (ctl.op)
      ALU_MUL: begin
        acc <= prod;
      end
      ALU_MAC: begin
        acc <= acc + prod;
      end
      ALU_ABS: begin
        neg   <= acc[ACC_W-1];
        mag_q <= mag[DIV_PRE +: MAG_W];
      end
      ALU_RCP: begin
        acc <= prod;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/line_follow_pd_steering_unit.sv
// Line-follow PD steering unit: sequencer, configuration registers and output stage.
//
// Input channel: sensor_bits with in_valid / in_stall. An item is taken when
// in_valid is high and in_stall is low; in_stall is low only while the
// sequencer is idle. Output channel: left_drive, right_drive, position_error
// and line_lost with out_valid / out_stall, one result per item.
// Each item runs through one shared multiplier: error lookup, proportional
// multiply, derivative multiply-accumulate, magnitude and shift by 2^11,
// multiply by the reciprocal of 105 and saturation, in six sequencer steps;
// a new item is taken only once the sequencer is back in idle.
// The result sits in an output register: while the receiver stalls, the block
// still takes the next item, and it holds in the saturation step until the
// register frees up. The user writes configuration through cfg_write / cfg_index /
// cfg_data while idle; the block does not enforce it. Unknown indexes are dropped.
// Reset (rst, synchronous) restores the register defaults, clears the stored
// previous error and empties the output register.
module line_follow_pd_steering_unit #(
  parameter int SENSOR_COUNT = lfpd_pkg::SENSOR_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [SENSOR_COUNT-1:0]          sensor_bits,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lfpd_pkg::drive_t                 left_drive,
  output lfpd_pkg::drive_t                 right_drive,
  output lfpd_pkg::err_t                   position_error,
  output logic                             line_lost,
  input  logic                             cfg_write,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfpd_pkg::CFG_W-1:0]       cfg_data
);
  import lfpd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ERR  = 6'b000010,
    S_MULP = 6'b000100,
    S_MULD = 6'b001000,
    S_ABS  = 6'b010000,
    S_RCP  = 6'b100000,
    S_SAT  = 6'b000000
  } state_t;

  state_t state, state_next;

  logic [SPEED_W-1:0] cruise_speed;
  logic [SPEED_W-1:0] drive_limit;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic               polarity;

  logic [SENSOR_COUNT-1:0] bits;
  err_t                    prev_error;
  err_t                    err;
  logic                    lost;
  err_t                    calc_err;
  logic                    calc_lost;

  alu_ctl_t                ctl;
  logic [QUO_W-1:0]        quo;
  logic                    neg;

  logic signed [DRIVE_W-1:0] turn;
  logic signed [SUM_W-1:0]   lim;
  logic signed [SUM_W-1:0]   left_sum;
  logic signed [SUM_W-1:0]   right_sum;
  logic signed [SUM_W-1:0]   left_sat;
  logic signed [SUM_W-1:0]   right_sat;
  logic                      load_out;

  lfpd_err #(.SENSOR_COUNT(SENSOR_COUNT)) u_err (
    .bits       (bits),
    .polarity   (polarity),
    .prev_error (prev_error),
    .err        (calc_err),
    .lost       (calc_lost)
  );

  lfpd_alu u_alu (
    .clk (clk),
    .ctl (ctl),
    .quo (quo),
    .neg (neg)
  );

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_SAT) && (!out_valid || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_speed <= CRUISE_RST;
      drive_limit  <= DRIVE_LIMIT_RST;
      prop_gain    <= PROP_GAIN_RST;
      deriv_gain   <= DERIV_GAIN_RST;
      polarity     <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CRUISE:      cruise_speed <= cfg_data[SPEED_W-1:0];
        REG_DRIVE_LIMIT: drive_limit  <= cfg_data[SPEED_W-1:0];
        REG_PROP_GAIN:   prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain   <= cfg_data[GAIN_W-1:0];
        REG_POLARITY:    polarity     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_ERR;
      S_ERR:   state_next = S_MULP;
      S_MULP:  state_next = S_MULD;
      S_MULD:  state_next = S_ABS;
      S_ABS:   state_next = S_RCP;
      S_RCP:   state_next = S_SAT;
      S_SAT:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op    = ALU_NOP;
    ctl.mul_a = DELTA_W'(err);
    ctl.mul_b = $signed({1'b0, prop_gain});
    case (state)
      S_MULP: ctl.op = ALU_MUL;
      S_MULD: begin
        ctl.op    = ALU_MAC;
        ctl.mul_a = DELTA_W'(err) - DELTA_W'(prev_error);
        ctl.mul_b = $signed({1'b0, deriv_gain});
      end
      S_ABS:   ctl.op = ALU_ABS;
      S_RCP:   ctl.op = ALU_RCP;
      default: ctl.op = ALU_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        prev_error <= err;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: sample, error and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      bits <= sensor_bits;
    end
    if (state == S_ERR) begin
      err  <= calc_err;
      lost <= calc_lost;
    end
    if (load_out) begin
      left_drive     <= left_sat[DRIVE_W-1:0];
      right_drive    <= right_sat[DRIVE_W-1:0];
      position_error <= err;
      line_lost      <= lost;
    end
  end

  assign turn      = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign lim       = $signed({2'b00, drive_limit});
  assign left_sum  = $signed({2'b00, cruise_speed}) + SUM_W'(turn);
  assign right_sum = $signed({2'b00, cruise_speed}) - SUM_W'(turn);

  always_comb begin
    if (left_sum > lim) begin
      left_sat = lim;
    end else if (left_sum < -lim) begin
      left_sat = -lim;
    end else begin
      left_sat = left_sum;
    end
    if (right_sum > lim) begin
      right_sat = lim;
    end else if (right_sum < -lim) begin
      right_sat = -lim;
    end else begin
      right_sat = right_sum;
    end
  end

  a_out_after_sat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SAT))
    else $error("result appeared without a saturation step");

  a_lost_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_lost |->
      position_error == ERR_W'(LOST_ERR) || position_error == -ERR_W'(LOST_ERR) ||
      position_error == '0)
    else $error("lost line with an error other than the fallback values");

  a_seen_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_lost |-> position_error <= 3360 && position_error >= -3360)
    else $error("centroid error out of the sensor span");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the line-follow PD steering unit.
module tb;
  import lfpd_pkg::*;

  localparam int     PITCH        = 840;
  localparam int     LOST_POS     = 4200;
  localparam longint TURN_SCALE   = 840 * 256;
  localparam int     DIR_ROWS     = 24;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 200;
  localparam int     SETTLE       = 4;
  localparam int     TAIL_CYCLES  = 40;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     HOLD_AT_ITEM = 250;
  localparam int     MAX_REPORTS  = 10;

  typedef struct {
    drive_t left;
    drive_t right;
    err_t   err;
    logic   lost;
  } drive_result_t;

  typedef struct {
    logic [7:0] bits;
    bit         typed;
    int         left;
    int         right;
    int         err;
    bit         lost;
  } sample_row_t;

  // Rows with typed results start from the reset settings and chain through
  // the stored error: lost line with zero, negative and positive history.
  sample_row_t sample_tab [DIR_ROWS] = '{
    '{8'h00, 1'b1, 300, 300,     0, 1'b1},
    '{8'h01, 1'b1, 140, 460, -3360, 1'b0},
    '{8'h00, 1'b1, 140, 460, -4200, 1'b1},
    '{8'h80, 1'b1, 510,  90,  3360, 1'b0},
    '{8'h00, 1'b1, 460, 140,  4200, 1'b1},
    '{8'hFF, 1'b1, 250, 350,     0, 1'b0},
    '{8'h18, 1'b1, 300, 300,     0, 1'b0},
    '{8'h00, 1'b1, 300, 300,     0, 1'b1},
    '{8'h03, 1'b0, 0, 0, 0, 1'b0},
    '{8'h07, 1'b0, 0, 0, 0, 1'b0},
    '{8'h0F, 1'b0, 0, 0, 0, 1'b0},
    '{8'h1F, 1'b0, 0, 0, 0, 1'b0},
    '{8'h3F, 1'b0, 0, 0, 0, 1'b0},
    '{8'h7F, 1'b0, 0, 0, 0, 1'b0},
    '{8'hFE, 1'b0, 0, 0, 0, 1'b0},
    '{8'hF0, 1'b0, 0, 0, 0, 1'b0},
    '{8'hC0, 1'b0, 0, 0, 0, 1'b0},
    '{8'h55, 1'b0, 0, 0, 0, 1'b0},
    '{8'hAA, 1'b0, 0, 0, 0, 1'b0},
    '{8'h81, 1'b0, 0, 0, 0, 1'b0},
    '{8'h24, 1'b0, 0, 0, 0, 1'b0},
    '{8'h42, 1'b0, 0, 0, 0, 1'b0},
    '{8'h10, 1'b0, 0, 0, 0, 1'b0},
    '{8'h02, 1'b0, 0, 0, 0, 1'b0}
  };

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    in_valid    = 1'b0;
  logic [SENSOR_COUNT-1:0] sensor_bits = '0;
  logic                    out_stall   = 1'b0;
  logic                    cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_W-1:0]        cfg_data    = '0;
  logic                    in_stall;
  logic                    out_valid;
  drive_t                  left_drive;
  drive_t                  right_drive;
  err_t                    position_error;
  logic                    line_lost;

  logic rx_hold = 1'b0;
  int   tx_idle = 36;
  int   rx_idle = 83;

  // Steering model state and register shadows.
  logic [SPEED_W-1:0] base_q;
  logic [SPEED_W-1:0] max_q;
  logic [GAIN_W-1:0]  prop_q;
  logic [GAIN_W-1:0]  deriv_q;
  logic               pol_q;
  err_t               prev_err_q;

  drive_result_t pending_drive_q [$];
  int items_sent    = 0;
  int results_seen  = 0;
  int lost_seen     = 0;
  int mismatches    = 0;
  int settings_done = 0;

  line_follow_pd_steering_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sensor_bits    (sensor_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .left_drive     (left_drive),
    .right_drive    (right_drive),
    .position_error (position_error),
    .line_lost      (line_lost),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic drive_result_t predict_drive(input logic [7:0] raw);
    logic [7:0]    on_line;
    int            i;
    int            active;
    int            wsum;
    int            pos;
    int            turn;
    int            lim;
    int            left_v;
    int            right_v;
    longint        num;
    drive_result_t r;
    on_line = pol_q ? raw : ~raw;
    active  = 0;
    wsum    = 0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      if (on_line[i]) begin
        active++;
        wsum += (i < SENSOR_COUNT / 2) ? i - SENSOR_COUNT / 2 : i - SENSOR_COUNT / 2 + 1;
      end
    end
    if (active == 0)
      pos = (prev_err_q > 0) ? LOST_POS : (prev_err_q < 0) ? -LOST_POS : 0;
    else
      pos = wsum * (PITCH / active);
    num = longint'(pos) * longint'(prop_q)
        + longint'(pos - int'(prev_err_q)) * longint'(deriv_q);
    // Signed divide truncates toward zero.
    turn    = int'(num / TURN_SCALE);
    lim     = int'(max_q);
    left_v  = int'(base_q) + turn;
    right_v = int'(base_q) - turn;
    if (left_v > lim) left_v = lim;
    else if (left_v < -lim) left_v = -lim;
    if (right_v > lim) right_v = lim;
    else if (right_v < -lim) right_v = -lim;
    r.left     = drive_t'(left_v);
    r.right    = drive_t'(right_v);
    r.err      = err_t'(pos);
    r.lost     = (active == 0);
    prev_err_q = err_t'(pos);
    return r;
  endfunction

  // Mostly plausible line shapes, written in on-line terms and then mapped
  // through the current polarity.
  function automatic logic [7:0] pick_sample();
    logic [7:0] on_line;
    int         sel;
    int         len;
    sel = $urandom_range(99);
    if (sel < 15) begin
      on_line = '0;
    end else if (sel < 55) begin
      len     = $urandom_range(3, 1);
      on_line = 8'((1 << len) - 1) << $urandom_range(8 - len);
    end else if (sel < 60) begin
      on_line = '1;
    end else begin
      on_line = 8'($urandom_range(255));
    end
    return pol_q ? on_line : ~on_line;
  endfunction

  task automatic send_item(input logic [7:0] raw, input bit typed,
                           input drive_result_t typed_res);
    int            gap;
    drive_result_t want;
    if (items_sent < 700) begin
      tx_idle = 36;
      rx_idle = 83;
    end else if (items_sent < 1400) begin
      tx_idle = 83;
      rx_idle = 36;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sensor_bits <= raw;
    do @(posedge clk); while (in_stall);
    want = predict_drive(raw);
    if (typed) want = typed_res;
    pending_drive_q.push_back(want);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves cfg_write high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_CRUISE:      base_q  = data[SPEED_W-1:0];
      REG_DRIVE_LIMIT: max_q   = data[SPEED_W-1:0];
      REG_PROP_GAIN:   prop_q  = data[GAIN_W-1:0];
      REG_DERIV_GAIN:  deriv_q = data[GAIN_W-1:0];
      REG_POLARITY:    pol_q   = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] base, top, kp, kd, pol,
                               input bit stray);
    int idx;
    wait_drained();
    write_reg(REG_CRUISE, base);
    write_reg(REG_DRIVE_LIMIT, top);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_POLARITY, pol);
    // Unused indexes must leave every register alone.
    if (stray)
      for (idx = int'(REG_POLARITY) + 1; idx < (1 << CFG_IDX_W); idx++)
        write_reg(CFG_IDX_W'(idx), CFG_W'($urandom));
    cfg_write <= 1'b0;
    settings_done++;
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_seen, field, want, got);
  endtask

  always @(posedge clk) out_stall <= rx_hold || ($urandom_range(99) < rx_idle);

  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with nothing pending", results_seen);
      end else begin
        want = pending_drive_q.pop_front();
        if (line_lost === 1'b1) lost_seen++;
        if (left_drive !== want.left)
          report_mismatch("left_drive", want.left, left_drive);
        if (right_drive !== want.right)
          report_mismatch("right_drive", want.right, right_drive);
        if (position_error !== want.err)
          report_mismatch("position_error", want.err, position_error);
        if (line_lost !== want.lost)
          report_mismatch("line_lost", want.lost, line_lost);
      end
    end
  end

  // Long receiver hold-off so the output register fills and the input stalls.
  initial begin : rx_hold_proc
    wait (items_sent >= HOLD_AT_ITEM);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #(10 * 3_000_000);
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int            ph;
    int            k;
    drive_result_t typed_res;
    base_q     = CRUISE_RST;
    max_q      = DRIVE_LIMIT_RST;
    prop_q     = PROP_GAIN_RST;
    deriv_q    = DERIV_GAIN_RST;
    pol_q      = 1'b1;
    prev_err_q = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_ROWS; k++) begin
      typed_res.left  = drive_t'(sample_tab[k].left);
      typed_res.right = drive_t'(sample_tab[k].right);
      typed_res.err   = err_t'(sample_tab[k].err);
      typed_res.lost  = sample_tab[k].lost;
      send_item(sample_tab[k].bits, sample_tab[k].typed, typed_res);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_setting(16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        1: apply_setting(16'd4095, 16'd4095, 16'd0, 16'hFFFF, 16'd1, 1'b0);
        // zero drive limit pins both wheels at zero
        2: apply_setting(16'd2048, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
        // upper bits beyond each register's width must be dropped
        3: apply_setting(16'hF12C, 16'hA3E8, 16'h1E00, 16'h0A00, 16'hFFFE, 1'b1);
        default: apply_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                               CFG_W'($urandom), CFG_W'($urandom), ph % 3 == 0);
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && ph % 2 == 1) wait_drained();
        send_item(pick_sample(), 1'b0, typed_res);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pending_drive_q.size();

    $display("summary: %0d items, %0d register settings after the defaults, %0d results, %0d lost",
             items_sent, settings_done, results_seen, lost_seen);
    $display("summary: both polarities, gain and limit extremes, zero limit, long hold; %0d bad",
             mismatches);
    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// File: files.f
design/lfpd_pkg.sv
design/lfpd_err.sv
design/lfpd_alu.sv
design/line_follow_pd_steering_unit.sv
tb/tb.sv
